FILE: rtl/tfpdc_pkg.sv
// ----------------------------------------------------------------------------
// tfpdc_pkg
// Shared types and fixed widths of the thermal fan phase-delay controller.
// ----------------------------------------------------------------------------
package tfpdc_pkg;

   localparam int THR_BITS      = 12;
   localparam int STEP_BITS     = 10;
   localparam int AVG_BITS      = 17;
   localparam int CMP_BITS      = 18;
   localparam int NUMER_BITS    = 20;
   localparam int SPAN_BITS     = 16;
   localparam int CSR_IDX_BITS  = 3;

   localparam int AVG_RESET     = 6400;
   localparam int TEMP_LOW      = -640;
   localparam int TEMP_HIGH     = 2080;
   localparam int SLOWEST_RESET = 8000;
   localparam int FASTEST_RESET = 1500;
   localparam int START_RESET   = 448;
   localparam int STOP_RESET    = 416;
   localparam int FULL_RESET    = 720;
   localparam int STEP_RESET    = 25;
   localparam int AVG_DIVISOR   = 5;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_START   = 3'd0,
      CSR_STOP    = 3'd1,
      CSR_FULL    = 3'd2,
      CSR_SLOWEST = 3'd3,
      CSR_FASTEST = 3'd4,
      CSR_STEP    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

FILE: rtl/tfpdc_ifs.sv
// ----------------------------------------------------------------------------
// tfpdc channel interfaces
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface tfpdc_req_if #(parameter int TEMP_BITS = 13);
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic signed [TEMP_BITS-1:0] sample_value;

   modport source (output valid, req_type, sample_value, input ready);
   modport sink   (input valid, req_type, sample_value, output ready);
endinterface

interface tfpdc_rsp_if #(parameter int DELAY_BITS = 14, parameter int TEMP_BITS = 13);
   logic                        valid;
   logic                        ready;
   logic                        fan_on;
   logic [DELAY_BITS-1:0]       goal_delay;
   logic [DELAY_BITS-1:0]       present_delay;
   logic signed [TEMP_BITS-1:0] smoothed_temperature;
   logic                        sample_rejected;

   modport source (output valid, fan_on, goal_delay, present_delay,
                   smoothed_temperature, sample_rejected, input ready);
   modport sink   (input valid, fan_on, goal_delay, present_delay,
                   smoothed_temperature, sample_rejected, output ready);
endinterface

interface tfpdc_csr_if #(parameter int DATA_BITS = 14);
   logic                                valid;
   logic                                ready;
   logic [tfpdc_pkg::CSR_IDX_BITS-1:0]  index;
   logic [DATA_BITS-1:0]                wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

FILE: rtl/tfpdc_sermul.sv
// ----------------------------------------------------------------------------
// tfpdc_sermul
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module tfpdc_sermul #(
   parameter int A_BITS = 16,
   parameter int B_BITS = 14
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [A_BITS-1:0]           op_a,
   input  logic [B_BITS-1:0]           op_b,
   output logic [A_BITS+B_BITS-1:0]    product,
   output tfpdc_pkg::unit_status_type  status
);
   import tfpdc_pkg::*;

   localparam int CNT_BITS = $clog2(B_BITS + 1);

   logic [A_BITS-1:0]   a_ff, a_in, hi_ff, hi_in;
   logic [B_BITS-1:0]   lo_ff, lo_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic [A_BITS:0]     sum;

   always_comb begin
      sum     = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : {(A_BITS+1){1'b0}});
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = op_a;
         hi_in   = '0;
         lo_in   = op_b;
         cnt_in  = CNT_BITS'(B_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum[A_BITS:1];
         lo_in  = {sum[0], lo_ff[B_BITS-1:1]};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign product = {hi_ff, lo_ff};
   assign status  = '{busy: busy_ff, done: done_ff};

endmodule

FILE: rtl/tfpdc_serdiv.sv
// ----------------------------------------------------------------------------
// tfpdc_serdiv
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tfpdc_serdiv #(
   parameter int DVD_BITS = 30,
   parameter int DVS_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [DVD_BITS-1:0]         dividend,
   input  logic [DVS_BITS-1:0]         divisor,
   output logic [DVD_BITS-1:0]         quotient,
   output tfpdc_pkg::unit_status_type  status
);
   import tfpdc_pkg::*;

   localparam int CNT_BITS = $clog2(DVD_BITS + 1);

   logic [DVS_BITS-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [DVD_BITS-1:0] quo_ff, quo_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic [DVS_BITS:0]   shifted, diff;
   logic                ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DVD_BITS-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = shifted >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
         cnt_in  = CNT_BITS'(DVD_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DVS_BITS-1:0] : shifted[DVS_BITS-1:0];
         quo_in = {quo_ff[DVD_BITS-2:0], ge};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign status   = '{busy: busy_ff, done: done_ff};

endmodule

FILE: rtl/thermal_fan_phase_delay_control_unit.sv
// ----------------------------------------------------------------------------
// thermal_fan_phase_delay_control_unit
// Temperature average, fan hysteresis, delay mapping and slew limiting.
//
//   channel  dir  handshake     word
//   req_bus  in   valid/ready   req_type, sample_value
//   rsp_bus  out  valid/ready   fan_on, goal_delay, present_delay,
//                               smoothed_temperature, sample_rejected
//   csr_bus  in   valid/ready   index, wdata (always ready)
//
// A tick or a rejected sample goes from accept straight to ST_DONE. A sample
// first runs the bit-serial divider for the average, then the hysteresis
// step and, when the delay is mapped, the bit-serial multiplier and the
// divider again before ST_DONE. One word is in work at a time.
// The response register lets the next word be accepted while one waits.
// Reset is synchronous; settings and control state reset, data registers do not.
// ----------------------------------------------------------------------------
module thermal_fan_phase_delay_control_unit #(
   parameter int DELAY_BITS = 14,
   parameter int TEMP_BITS  = 13
) (
   input logic         clock,
   input logic         reset,
   tfpdc_req_if.sink   req_bus,
   tfpdc_rsp_if.source rsp_bus,
   tfpdc_csr_if.sink   csr_bus
);
   import tfpdc_pkg::*;

   localparam int WIDE_BITS = SPAN_BITS + DELAY_BITS;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_AVG  = 6'b000010,
      ST_HYST = 6'b000100,
      ST_MUL  = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type                   state_ff, state_in;
   logic [THR_BITS-1:0]         start_ff, stop_ff, full_ff;
   logic [DELAY_BITS-1:0]       slow_ff, fast_ff;
   logic [STEP_BITS-1:0]        step_ff;
   logic signed [AVG_BITS-1:0]  avg_ff, avg_in;
   logic                        en_ff, en_in;
   logic [DELAY_BITS-1:0]       tgt_ff, tgt_in, cur_ff, cur_in;
   logic                        neg_ff, neg_in, rej_ff, rej_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        o_fan_ff;
   logic [DELAY_BITS-1:0]       o_goal_ff, o_pres_ff;
   logic signed [TEMP_BITS-1:0] o_temp_ff;
   logic                        o_rej_ff;
   logic                        load_rsp;

   logic signed [CMP_BITS-1:0]   lo_w, hi_w, stop_w, avg_w, raw_w, den_w, clamp_w, num_w;
   logic signed [NUMER_BITS-1:0] numer;
   logic [NUMER_BITS-1:0]        numer_mag;
   logic [DELAY_BITS-1:0]        span_delay;
   logic [DELAY_BITS:0]          up_sum, tgt_plus;
   logic [AVG_BITS-1:0]          quo_mag;
   logic signed [AVG_BITS-1:0]   shown_sh, shown;

   logic                  mul_start, div_start;
   logic [WIDE_BITS-1:0]  product, div_dvd, div_quo;
   logic [SPAN_BITS-1:0]  div_dvs;
   unit_status_type       mul_status, div_status;

   tfpdc_sermul #(.A_BITS(SPAN_BITS), .B_BITS(DELAY_BITS)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (num_w[SPAN_BITS-1:0]),
      .op_b    (span_delay),
      .product (product),
      .status  (mul_status)
   );

   tfpdc_serdiv #(.DVD_BITS(WIDE_BITS), .DVS_BITS(SPAN_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .quotient (div_quo),
      .status   (div_status)
   );

   // register writes
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= THR_BITS'(START_RESET);
         stop_ff  <= THR_BITS'(STOP_RESET);
         full_ff  <= THR_BITS'(FULL_RESET);
         slow_ff  <= DELAY_BITS'(SLOWEST_RESET);
         fast_ff  <= DELAY_BITS'(FASTEST_RESET);
         step_ff  <= STEP_BITS'(STEP_RESET);
      end else if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_START:   start_ff <= csr_bus.wdata[THR_BITS-1:0];
            CSR_STOP:    stop_ff  <= csr_bus.wdata[THR_BITS-1:0];
            CSR_FULL:    full_ff  <= csr_bus.wdata[THR_BITS-1:0];
            CSR_SLOWEST: slow_ff  <= csr_bus.wdata;
            CSR_FASTEST: fast_ff  <= csr_bus.wdata;
            CSR_STEP:    step_ff  <= csr_bus.wdata[STEP_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // datapath helpers
   always_comb begin
      lo_w    = $signed({2'b00, start_ff, 4'b0000});
      hi_w    = $signed({2'b00, full_ff, 4'b0000});
      stop_w  = $signed({2'b00, stop_ff, 4'b0000});
      avg_w   = {{(CMP_BITS-AVG_BITS){avg_ff[AVG_BITS-1]}}, avg_ff};
      raw_w   = {{(CMP_BITS-TEMP_BITS){req_bus.sample_value[TEMP_BITS-1]}},
                 req_bus.sample_value};
      den_w   = hi_w - lo_w;
      if (avg_w < lo_w) begin
         clamp_w = lo_w;
      end else if (avg_w > hi_w) begin
         clamp_w = hi_w;
      end else begin
         clamp_w = avg_w;
      end
      num_w      = clamp_w - lo_w;
      span_delay = slow_ff - fast_ff;
      numer      = ({{(NUMER_BITS-CMP_BITS){raw_w[CMP_BITS-1]}}, raw_w} <<< 4)
                 + ({{(NUMER_BITS-CMP_BITS){avg_w[CMP_BITS-1]}}, avg_w} <<< 2);
      numer_mag  = numer[NUMER_BITS-1] ? NUMER_BITS'(-numer) : NUMER_BITS'(numer);
      up_sum     = {1'b0, cur_ff} + (DELAY_BITS+1)'(step_ff);
      tgt_plus   = {1'b0, tgt_ff} + (DELAY_BITS+1)'(step_ff);
      quo_mag    = div_quo[AVG_BITS-1:0];
      shown_sh   = avg_ff >>> 4;
      shown      = (avg_ff[AVG_BITS-1] && (avg_ff[3:0] != 4'd0)) ?
                   shown_sh + AVG_BITS'(1) : shown_sh;
   end

   assign div_dvd = (state_ff == ST_IDLE) ?
                    {{(WIDE_BITS-NUMER_BITS){1'b0}}, numer_mag} : product;
   assign div_dvs = (state_ff == ST_IDLE) ?
                    SPAN_BITS'(AVG_DIVISOR) : den_w[SPAN_BITS-1:0];

   assign req_bus.ready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      avg_in    = avg_ff;
      en_in     = en_ff;
      tgt_in    = tgt_ff;
      cur_in    = cur_ff;
      neg_in    = neg_ff;
      rej_in    = rej_ff;
      mul_start = 1'b0;
      div_start = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               rej_in   = 1'b0;
               state_in = ST_DONE;
               if (req_bus.req_type) begin
                  if (cur_ff < tgt_ff) begin
                     cur_in = (up_sum > {1'b0, tgt_ff}) ? tgt_ff : up_sum[DELAY_BITS-1:0];
                  end else if (cur_ff > tgt_ff) begin
                     cur_in = ({1'b0, cur_ff} > tgt_plus) ? cur_ff - DELAY_BITS'(step_ff)
                                                          : tgt_ff;
                  end
               end else if (raw_w < CMP_BITS'(TEMP_LOW) ||
                            raw_w > CMP_BITS'(TEMP_HIGH)) begin
                  rej_in = 1'b1;
               end else begin
                  neg_in    = numer[NUMER_BITS-1];
                  div_start = 1'b1;
                  state_in  = ST_AVG;
               end
            end
         end
         ST_AVG: begin
            if (div_status.done) begin
               avg_in   = neg_ff ? -$signed(quo_mag) : $signed(quo_mag);
               state_in = ST_HYST;
            end
         end
         ST_HYST: begin
            state_in = ST_DONE;
            priority if (!en_ff) begin
               if (avg_w >= lo_w) begin
                  en_in  = 1'b1;
                  tgt_in = slow_ff;
               end
            end else if (avg_w < stop_w) begin
               en_in = 1'b0;
            end else if (den_w == '0) begin
               tgt_in = fast_ff;
            end else if (fast_ff > slow_ff) begin
               tgt_in = slow_ff;
            end else if (den_w < 0) begin
               tgt_in = (avg_w < lo_w) ? slow_ff : fast_ff;
            end else begin
               mul_start = 1'b1;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_status.done) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               tgt_in   = slow_ff - div_quo[DELAY_BITS-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = load_rsp | (rsp_valid_ff & ~rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      if (load_rsp) begin
         o_fan_ff  <= en_ff;
         o_goal_ff <= tgt_ff;
         o_pres_ff <= cur_ff;
         o_temp_ff <= shown[TEMP_BITS-1:0];
         o_rej_ff  <= rej_ff;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         avg_ff       <= AVG_BITS'(AVG_RESET);
         en_ff        <= 1'b0;
         tgt_ff       <= DELAY_BITS'(SLOWEST_RESET);
         cur_ff       <= DELAY_BITS'(SLOWEST_RESET);
         rej_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         avg_ff       <= avg_in;
         en_ff        <= en_in;
         tgt_ff       <= tgt_in;
         cur_ff       <= cur_in;
         rej_ff       <= rej_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid                = rsp_valid_ff;
   assign rsp_bus.fan_on               = o_fan_ff;
   assign rsp_bus.goal_delay           = o_goal_ff;
   assign rsp_bus.present_delay        = o_pres_ff;
   assign rsp_bus.smoothed_temperature = o_temp_ff;
   assign rsp_bus.sample_rejected      = o_rej_ff;

endmodule

FILE: tb/tb_thermal_fan_phase_delay_control_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thermal_fan_phase_delay_control_unit
// Self-checking bench for the fan phase-delay controller. Each accepted word
// runs through an in-bench copy of the averaging, hysteresis, delay mapping
// and slew logic. Every response is compared field by field with the oldest
// prediction. Stimulus covers range limits, hysteresis, span corner cases,
// register writes and a long response stall. It then runs random phases
// across register settings, with bursty requests and patterned back-pressure.
// ----------------------------------------------------------------------------
module tb_thermal_fan_phase_delay_control_unit;
   import tfpdc_pkg::*;

   localparam int DELAY_W        = 14;
   localparam int TEMP_W         = 13;
   localparam int IDLE_LIMIT     = 3000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 100;
   localparam int PHASE_WORDS    = 115;

   localparam bit KIND_SAMPLE    = 1'b0;
   localparam bit KIND_TICK      = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_HI = 3'd7;

   localparam int READY_ALWAYS   = 0;
   localparam int READY_MOSTLY   = 1;
   localparam int READY_SPARSE   = 2;

   typedef struct {
      bit                        fan_on;
      logic [DELAY_W-1:0]        goal_delay;
      logic [DELAY_W-1:0]        present_delay;
      logic signed [TEMP_W-1:0]  smoothed_temperature;
      bit                        sample_rejected;
   } fan_outputs_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tfpdc_req_if #(.TEMP_BITS(TEMP_W))                     req_bus ();
   tfpdc_rsp_if #(.DELAY_BITS(DELAY_W), .TEMP_BITS(TEMP_W)) rsp_bus ();
   tfpdc_csr_if #(.DATA_BITS(DELAY_W))                    csr_bus ();

   thermal_fan_phase_delay_control_unit #(
      .DELAY_BITS(DELAY_W),
      .TEMP_BITS (TEMP_W)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   // controller image
   int start_thr = START_RESET;
   int stop_thr  = STOP_RESET;
   int full_thr  = FULL_RESET;
   int slow_dly  = SLOWEST_RESET;
   int fast_dly  = FASTEST_RESET;
   int step_dly  = STEP_RESET;
   int avg_temp  = AVG_RESET;
   bit fan_state = 1'b0;
   int goal_dly  = SLOWEST_RESET;
   int now_dly   = SLOWEST_RESET;

   fan_outputs_type predicted_outputs[$];
   int error_count = 0;
   int idle_cycles = 0;
   int burst_left  = 0;
   bit gaps_on     = 1'b1;
   int ready_mode  = READY_MOSTLY;
   bit hold_request = 1'b0;
   int hold_left   = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int mapped_delay();
      longint lo, hi, clamped, num, den;
      lo = start_thr * 16;
      hi = full_thr * 16;
      clamped = avg_temp;
      if (clamped < lo) begin
         clamped = lo;
      end else if (clamped > hi) begin
         clamped = hi;
      end
      num = clamped - lo;
      den = hi - lo;
      if (den == 0) return fast_dly;
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      if (fast_dly > slow_dly) return slow_dly;
      return slow_dly - int'((num * longint'(slow_dly - fast_dly)) / den);
   endfunction

   function automatic fan_outputs_type advance_fan_control(bit kind,
                                                           logic signed [TEMP_W-1:0] value);
      fan_outputs_type res;
      int raw;
      raw = value;
      res.sample_rejected = 1'b0;
      if (kind == KIND_SAMPLE) begin
         if (raw < TEMP_LOW || raw > TEMP_HIGH) begin
            res.sample_rejected = 1'b1;
         end else begin
            avg_temp = (raw * 16 + avg_temp * 4) / AVG_DIVISOR;
            if (!fan_state) begin
               if (avg_temp >= start_thr * 16) begin
                  fan_state = 1'b1;
                  goal_dly  = slow_dly;
               end
            end else if (avg_temp < stop_thr * 16) begin
               fan_state = 1'b0;
            end else begin
               goal_dly = mapped_delay();
            end
         end
      end else if (now_dly < goal_dly) begin
         now_dly += step_dly;
         if (now_dly > goal_dly) now_dly = goal_dly;
      end else if (now_dly > goal_dly) begin
         if (now_dly > goal_dly + step_dly) now_dly -= step_dly;
         else now_dly = goal_dly;
      end
      res.fan_on               = fan_state;
      res.goal_delay           = goal_dly[DELAY_W-1:0];
      res.present_delay        = now_dly[DELAY_W-1:0];
      res.smoothed_temperature = TEMP_W'(avg_temp / 16);
      return res;
   endfunction

   function automatic void apply_register(logic [CSR_IDX_BITS-1:0] idx,
                                          logic [DELAY_W-1:0] data);
      unique case (idx)
         CSR_START:   start_thr = data[THR_BITS-1:0];
         CSR_STOP:    stop_thr  = data[THR_BITS-1:0];
         CSR_FULL:    full_thr  = data[THR_BITS-1:0];
         CSR_SLOWEST: slow_dly  = data;
         CSR_FASTEST: fast_dly  = data;
         CSR_STEP:    step_dly  = data[STEP_BITS-1:0];
         default: ;
      endcase
   endfunction

   function automatic logic signed [TEMP_W-1:0] pick_sample();
      int lo, hi, pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) return TEMP_W'($urandom);
      if (pick >= 80) return TEMP_W'(TEMP_LOW + int'($urandom_range(0, TEMP_HIGH - TEMP_LOW)));
      lo = start_thr;
      hi = start_thr;
      if (stop_thr < lo) lo = stop_thr;
      if (full_thr < lo) lo = full_thr;
      if (stop_thr > hi) hi = stop_thr;
      if (full_thr > hi) hi = full_thr;
      lo = lo - 160;
      hi = hi + 160;
      if (lo < TEMP_LOW) lo = TEMP_LOW;
      if (hi > TEMP_HIGH) hi = TEMP_HIGH;
      return TEMP_W'(lo + int'($urandom_range(0, hi - lo)));
   endfunction

   task automatic send_word(bit kind, logic signed [TEMP_W-1:0] value);
      int gap;
      req_bus.valid        <= 1'b1;
      req_bus.req_type     <= kind;
      req_bus.sample_value <= value;
      do @(posedge clock); while (!req_bus.ready);
      predicted_outputs.push_back(advance_fan_control(kind, value));
      if (gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(1, 6);
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic wait_drain();
      req_bus.valid <= 1'b0;
      while (predicted_outputs.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_BITS-1:0] idx, int value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= DELAY_W'(value);
      do @(posedge clock); while (!csr_bus.ready);
      apply_register(idx, DELAY_W'(value));
   endtask

   task automatic load_settings(int start_t, int stop_t, int full_t,
                                int slow_t, int fast_t, int step_t);
      wait_drain();
      write_register(CSR_START,   start_t);
      write_register(CSR_STOP,    stop_t);
      write_register(CSR_FULL,    full_t);
      write_register(CSR_SLOWEST, slow_t);
      write_register(CSR_FASTEST, fast_t);
      write_register(CSR_STEP,    step_t);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic test_range_limits();
      send_word(KIND_SAMPLE, TEMP_W'(TEMP_LOW));
      send_word(KIND_SAMPLE, TEMP_W'(TEMP_LOW - 1));
      send_word(KIND_SAMPLE, TEMP_W'(TEMP_HIGH));
      send_word(KIND_SAMPLE, TEMP_W'(TEMP_HIGH + 1));
      send_word(KIND_SAMPLE, TEMP_W'(-4096));
      send_word(KIND_SAMPLE, TEMP_W'(4095));
   endtask

   task automatic test_hysteresis();
      repeat (3) send_word(KIND_SAMPLE, TEMP_W'(1000));
      send_word(KIND_SAMPLE, TEMP_W'(600));
      repeat (2) send_word(KIND_TICK, TEMP_W'($urandom));
      repeat (3) send_word(KIND_SAMPLE, TEMP_W'(TEMP_LOW));
      send_word(KIND_TICK, TEMP_W'($urandom));
   endtask

   task automatic test_zero_span();
      load_settings(600, 500, 600, SLOWEST_RESET, FASTEST_RESET, STEP_RESET);
      repeat (3) send_word(KIND_SAMPLE, TEMP_W'(900));
   endtask

   task automatic test_inverted_span();
      load_settings(700, 200, 300, SLOWEST_RESET, FASTEST_RESET, STEP_RESET);
      repeat (3) send_word(KIND_SAMPLE, TEMP_W'(800));
   endtask

   task automatic test_inverted_delays();
      load_settings(START_RESET, STOP_RESET, FULL_RESET, 1000, 9000, 1023);
      send_word(KIND_SAMPLE, TEMP_W'(650));
      send_word(KIND_TICK, TEMP_W'($urandom));
      send_word(KIND_SAMPLE, TEMP_W'(650));
   endtask

   task automatic test_spare_index();
      wait_drain();
      write_register(CSR_SPARE_LO, 16383);
      write_register(CSR_SPARE_HI, 0);
      csr_bus.valid <= 1'b0;
      send_word(KIND_TICK, TEMP_W'($urandom));
   endtask

   task automatic test_output_stall();
      load_settings(START_RESET, STOP_RESET, FULL_RESET,
                    SLOWEST_RESET, FASTEST_RESET, STEP_RESET);
      gaps_on = 1'b0;
      hold_request = 1'b1;
      repeat (30) begin
         if ($urandom_range(0, 1) == 0) send_word(KIND_TICK, TEMP_W'($urandom));
         else send_word(KIND_SAMPLE, pick_sample());
      end
      gaps_on = 1'b1;
   endtask

   task automatic test_random_phases();
      int a, s, f, sl, fa, st;
      for (int phase = 0; phase < 10; phase++) begin
         unique case (phase)
            0: begin
               a = START_RESET; s = STOP_RESET; f = FULL_RESET;
               sl = SLOWEST_RESET; fa = FASTEST_RESET; st = STEP_RESET;
            end
            1: begin
               a = 0; s = 0; f = 0; sl = 0; fa = 0; st = 0;
            end
            2: begin
               a = 0; s = 0; f = TEMP_HIGH; sl = 16383; fa = 0; st = 1023;
            end
            3: begin
               a = TEMP_HIGH; s = TEMP_HIGH; f = TEMP_HIGH; sl = 16383; fa = 16383; st = 1;
            end
            default: begin
               if ($urandom_range(0, 7) == 0) begin
                  a = $urandom_range(0, TEMP_HIGH);
                  s = $urandom_range(0, TEMP_HIGH);
                  f = $urandom_range(0, TEMP_HIGH);
               end else begin
                  a = $urandom_range(100, 1800);
                  s = a - int'($urandom_range(0, 100));
                  f = a + int'($urandom_range(0, 280));
               end
               if ($urandom_range(0, 7) == 0) begin
                  sl = $urandom_range(0, 16383);
                  fa = $urandom_range(0, 16383);
                  st = $urandom_range(0, 1023);
               end else begin
                  sl = $urandom_range(4000, 16383);
                  fa = $urandom_range(0, sl);
                  st = $urandom_range(1, 300);
               end
            end
         endcase
         load_settings(a, s, f, sl, fa, st);
         gaps_on    = (phase != 4);
         ready_mode = phase % 3;
         repeat (PHASE_WORDS) begin
            if ($urandom_range(0, 99) < 45) send_word(KIND_TICK, TEMP_W'($urandom));
            else send_word(KIND_SAMPLE, pick_sample());
         end
      end
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            unique case (ready_mode)
               READY_ALWAYS: rsp_bus.ready <= 1'b1;
               READY_MOSTLY: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               default:      rsp_bus.ready <= ($urandom_range(0, 2) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      fan_outputs_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (predicted_outputs.size() == 0) begin
            $error("unexpected response word");
            error_count++;
         end else begin
            want = predicted_outputs.pop_front();
            if (rsp_bus.fan_on !== want.fan_on) begin
               $error("fan_on expected %0d actual %0d", want.fan_on, rsp_bus.fan_on);
               error_count++;
            end
            if (rsp_bus.goal_delay !== want.goal_delay) begin
               $error("goal_delay expected %0d actual %0d",
                      want.goal_delay, rsp_bus.goal_delay);
               error_count++;
            end
            if (rsp_bus.present_delay !== want.present_delay) begin
               $error("present_delay expected %0d actual %0d",
                      want.present_delay, rsp_bus.present_delay);
               error_count++;
            end
            if (rsp_bus.smoothed_temperature !== want.smoothed_temperature) begin
               $error("smoothed_temperature expected %0d actual %0d",
                      want.smoothed_temperature, rsp_bus.smoothed_temperature);
               error_count++;
            end
            if (rsp_bus.sample_rejected !== want.sample_rejected) begin
               $error("sample_rejected expected %0d actual %0d",
                      want.sample_rejected, rsp_bus.sample_rejected);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("thermal_fan_phase_delay_control_unit test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_bus.valid        <= 1'b0;
      req_bus.req_type     <= KIND_SAMPLE;
      req_bus.sample_value <= '0;
      csr_bus.valid        <= 1'b0;
      csr_bus.index        <= CSR_START;
      csr_bus.wdata        <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_range_limits();
      test_hysteresis();
      test_zero_span();
      test_inverted_span();
      test_inverted_delays();
      test_spare_index();
      test_output_stall();
      test_random_phases();
      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("thermal_fan_phase_delay_control_unit test passed");
      end else begin
         $display("thermal_fan_phase_delay_control_unit test failed");
      end
      $finish;
   end

endmodule
